// ===== src/ccs_pkg.sv =====
// Shared types, constants and helpers for the canonical closed-syncmer sampler.
package ccs_pkg;

    localparam int unsigned MaxWindow = 32;

    localparam logic [63:0] Xp1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] Xp2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] Xp3 = 64'h165667B19E3779F9;
    localparam logic [63:0] Xp4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] Xp5 = 64'h27D4EB2F165667C5;

    localparam logic [2:0] BaseBad = 3'd4;

    localparam logic CfgKmer = 1'b0;
    localparam logic CfgSmer = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_HASH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] val;
        logic [31:0] pos;
    } t_entry;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] r;
        unique case (ch)
            8'h41, 8'h61: r = 3'd0;
            8'h43, 8'h63: r = 3'd1;
            8'h47, 8'h67: r = 3'd2;
            8'h54, 8'h74: r = 3'd3;
            default:      r = BaseBad;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] len_mask(input logic [5:0] n);
        logic [63:0] r;
        if (n >= 6'd32) r = '1;
        else            r = (64'd1 << {n[4:0], 1'b0}) - 64'd1;
        return r;
    endfunction

endpackage

// ===== src/ccs_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface ccs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  nucleotide;
    logic        first_of_sequence;
    logic [31:0] sequence_offset;

    modport source (output valid, nucleotide, first_of_sequence, sequence_offset,
                    input ready);
    modport sink (input valid, nucleotide, first_of_sequence, sequence_offset,
                  output ready);
endinterface

interface ccs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] kmer_hash;
    logic [31:0] kmer_position;

    modport source (output valid, kmer_hash, kmer_position, input ready);
    modport sink (input valid, kmer_hash, kmer_position, output ready);
endinterface

// ===== src/ccs_cell.sv =====
// One window cell: holds an s-mer value and its position, loads from its neighbor or the new word.
module ccs_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  ccs_pkg::t_entry i_entry,
    output ccs_pkg::t_entry o_entry
);
    ccs_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
endmodule

// ===== src/ccs_hash.sv =====
// XXH64 of one 64-bit word, seed 0, on a shared 32x32 multiplier.
module ccs_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key,
    output logic        o_done,
    output logic [63:0] o_hash
);
    logic        r_busy, n_busy;
    logic [2:0]  r_stage, n_stage;
    logic [1:0]  r_part, n_part;
    logic [63:0] r_op, n_op;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_hash, n_hash;
    logic        r_done, n_done;

    logic [63:0] w_b;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod, w_full, w_h;

    always_comb begin
        unique case (r_stage)
            3'd0:    w_b = ccs_pkg::Xp2;
            3'd1:    w_b = ccs_pkg::Xp1;
            3'd2:    w_b = ccs_pkg::Xp1;
            3'd3:    w_b = ccs_pkg::Xp2;
            default: w_b = ccs_pkg::Xp3;
        endcase
    end

    always_comb begin
        unique case (r_part)
            2'd0:    begin w_ma = r_op[31:0];  w_mb = w_b[31:0];  end
            2'd1:    begin w_ma = r_op[63:32]; w_mb = w_b[31:0];  end
            default: begin w_ma = r_op[31:0];  w_mb = w_b[63:32]; end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_full = r_acc + {w_prod[31:0], 32'd0};

    always_comb begin
        n_busy  = r_busy;
        n_stage = r_stage;
        n_part  = r_part;
        n_op    = r_op;
        n_acc   = r_acc;
        n_hash  = r_hash;
        n_done  = 1'b0;
        w_h     = '0;
        if (i_start) begin
            n_busy  = 1'b1;
            n_stage = '0;
            n_part  = '0;
            n_op    = i_key;
        end else if (r_busy) begin
            unique case (r_part)
                2'd0: begin
                    n_acc  = w_prod;
                    n_part = 2'd1;
                end
                2'd1: begin
                    n_acc  = w_full;
                    n_part = 2'd2;
                end
                default: begin
                    n_part  = 2'd0;
                    n_stage = r_stage + 3'd1;
                    unique case (r_stage)
                        3'd0: n_op = {w_full[32:0], w_full[63:33]};
                        3'd1: begin
                            w_h  = (ccs_pkg::Xp5 + 64'd8) ^ w_full;
                            n_op = {w_h[36:0], w_h[63:37]};
                        end
                        3'd2: begin
                            w_h  = w_full + ccs_pkg::Xp4;
                            n_op = w_h ^ (w_h >> 33);
                        end
                        3'd3: n_op = w_full ^ (w_full >> 29);
                        default: begin
                            n_hash = w_full ^ (w_full >> 32);
                            n_busy = 1'b0;
                            n_done = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_stage <= n_stage;
        r_part  <= n_part;
        r_op    <= n_op;
        r_acc   <= n_acc;
        r_hash  <= n_hash;
    end

    assign o_done = r_done;
    assign o_hash = r_hash;
endmodule

// ===== src/canonical_closed_syncmer_sampler.sv =====
// Top level: canonical closed-syncmer sampler with a shifting row of window cells.
// A base that neither completes nor slides a window is taken in the idle state alone; a slide
// that keeps its minimum also passes through the check state; a window fill or a minimum rescan
// adds a rotation of the W = k-s+1 live cells through the cell row; a hit adds XXH64 on the
// shared 32x32 multiplier plus the output handshake. One base is in work at a time.
// Reset (synchronous, active low): k=20, s=16, words, run, window and minimum cleared.
module canonical_closed_syncmer_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    ccs_in_if.sink      i_in,
    ccs_out_if.source   o_out
);
    // Configuration
    logic [5:0] r_k, r_s;

    // Control state
    ccs_pkg::t_state r_state, n_state;
    logic [63:0] r_fk, n_fk, r_rk, n_rk, r_fs, n_fs, r_rs, n_rs;
    logic [5:0]  r_run, n_run;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_minv, n_minv;
    logic [31:0] r_minpos, n_minpos;
    logic        r_minok, n_minok;
    logic [31:0] r_idx, n_idx, r_off, n_off;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_rescan, n_rescan;
    logic        r_outv;
    // Payload held for the current base
    logic [31:0] r_spos, n_spos;
    logic [63:0] r_yk, n_yk;
    logic [31:0] r_kpos, n_kpos;

    // Decode of the incoming word
    logic        w_acc, w_len_ok, w_first;
    logic [5:0]  w_w;
    logic [2:0]  w_code;
    logic [1:0]  w_c;
    logic [63:0] w_fk0, w_rk0, w_fs0, w_rs0, w_minv0;
    logic [5:0]  w_run0, w_fill0;
    logic        w_minok0;
    logic [31:0] w_minpos0, w_idx0, w_off0;
    logic [63:0] w_ys, w_dropped;
    logic [6:0]  w_shk, w_shs;
    logic        w_hit;

    // Cell row control
    logic            w_cell_en, w_rotate, w_hash_start, w_slot;
    logic            w_hash_done;
    logic [63:0]     w_hash;
    ccs_pkg::t_entry w_new;
    ccs_pkg::t_entry w_cell [ccs_pkg::MaxWindow];

    assign w_acc    = i_in.valid && i_in.ready;
    assign w_w      = r_k - r_s + 6'd1;
    assign w_len_ok = (r_k != 6'd0) && (r_s != 6'd0) && (r_k <= 6'd32) && (r_s <= r_k);
    assign w_first  = i_in.first_of_sequence;
    assign w_code   = ccs_pkg::base_code(i_in.nucleotide);
    assign w_c      = w_code[1:0];
    assign w_shk    = {1'b0, r_k - 6'd1} << 1;
    assign w_shs    = {1'b0, r_s - 6'd1} << 1;
    assign w_dropped = w_cell[0].val;
    assign w_hit    = r_minok && (r_minpos == r_spos || r_minpos == w_cell[0].pos);
    // While the window fills, the new word lands in the cell at the fill count
    assign w_slot   = w_fill0 < w_w;

    // Start of the run as seen by this base: a new sequence clears it
    always_comb begin
        w_fk0     = w_first ? '0 : r_fk;
        w_rk0     = w_first ? '0 : r_rk;
        w_fs0     = w_first ? '0 : r_fs;
        w_rs0     = w_first ? '0 : r_rs;
        w_run0    = w_first ? '0 : r_run;
        w_fill0   = w_first ? '0 : r_fill;
        w_minv0   = w_first ? '1 : r_minv;
        w_minok0  = w_first ? 1'b0 : r_minok;
        w_minpos0 = w_first ? '0 : r_minpos;
        w_idx0    = w_first ? '0 : r_idx;
        w_off0    = w_first ? i_in.sequence_offset : r_off;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ccs_pkg::ST_IDLE: begin
                if (w_acc && w_len_ok && !w_code[2] && n_run >= r_s) begin
                    if (w_fill0 + 6'd1 == w_w) begin
                        n_state = ccs_pkg::ST_SCAN;
                    end else if (w_fill0 + 6'd1 > w_w) begin
                        n_state = (w_dropped == w_minv0) ? ccs_pkg::ST_SCAN
                                                         : ccs_pkg::ST_CHECK;
                    end
                end
            end
            ccs_pkg::ST_SCAN:  if (r_cnt == 6'd1) n_state = ccs_pkg::ST_CHECK;
            ccs_pkg::ST_CHECK: n_state = w_hit ? ccs_pkg::ST_HASH : ccs_pkg::ST_IDLE;
            ccs_pkg::ST_HASH:  if (w_hash_done) n_state = ccs_pkg::ST_OUT;
            ccs_pkg::ST_OUT:   if (o_out.ready) n_state = ccs_pkg::ST_IDLE;
            default:           n_state = ccs_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        i_in.ready   = 1'b0;
        w_cell_en    = 1'b0;
        w_rotate     = 1'b0;
        w_hash_start = 1'b0;
        unique case (r_state)
            ccs_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                w_cell_en  = w_acc && w_len_ok && !w_code[2] && n_run >= r_s;
            end
            ccs_pkg::ST_SCAN: begin
                w_cell_en = 1'b1;
                w_rotate  = 1'b1;
            end
            ccs_pkg::ST_CHECK: w_hash_start = w_hit;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_fk = r_fk; n_rk = r_rk; n_fs = r_fs; n_rs = r_rs;
        n_run = r_run; n_fill = r_fill;
        n_minv = r_minv; n_minpos = r_minpos; n_minok = r_minok;
        n_idx = r_idx; n_off = r_off;
        n_cnt = r_cnt; n_rescan = r_rescan;
        n_spos = r_spos; n_yk = r_yk; n_kpos = r_kpos;
        w_ys = '0;
        if (r_state == ccs_pkg::ST_IDLE && w_acc) begin
            n_idx = w_idx0 + 32'd1;
            n_off = w_off0;
            if (!w_len_ok || w_code[2]) begin
                // break: drop the run
                n_fk = '0; n_rk = '0; n_fs = '0; n_rs = '0;
                n_run = '0; n_fill = '0;
                n_minv = '1; n_minok = 1'b0; n_minpos = '0;
            end else begin
                n_fk  = ((w_fk0 << 2) | 64'(w_c)) & ccs_pkg::len_mask(r_k);
                n_rk  = (w_rk0 >> 2) | ((64'd3 - 64'(w_c)) << w_shk[5:0]);
                n_fs  = ((w_fs0 << 2) | 64'(w_c)) & ccs_pkg::len_mask(r_s);
                n_rs  = (w_rs0 >> 2) | ((64'd3 - 64'(w_c)) << w_shs[5:0]);
                n_run = (w_run0 == 6'd63) ? w_run0 : w_run0 + 6'd1;
                n_fill   = w_fill0;
                n_minv   = w_minv0;
                n_minok  = w_minok0;
                n_minpos = w_minpos0;
                w_ys   = (n_fs < n_rs) ? n_fs : n_rs;
                n_spos = w_idx0 - 32'(r_s) + 32'd1;
                n_yk   = (n_fk < n_rk) ? n_fk : n_rk;
                n_kpos = w_off0 + w_idx0 - 32'(r_k) + 32'd1;
                n_cnt  = w_w;
                if (n_run >= r_s) begin
                    if (w_fill0 + 6'd1 < w_w) begin
                        n_fill = w_fill0 + 6'd1;
                    end else if (w_fill0 + 6'd1 == w_w) begin
                        // first full window: leftmost strict minimum
                        n_fill   = w_w;
                        n_rescan = 1'b0;
                    end else if (w_dropped == w_minv0) begin
                        // minimum leaves: rescan, rightmost minimum wins
                        n_rescan = 1'b1;
                        n_minv   = '1;
                        n_minpos = n_spos;
                        n_minok  = 1'b1;
                    end else if (w_ys < w_minv0) begin
                        n_minv   = w_ys;
                        n_minpos = n_spos;
                        n_minok  = 1'b1;
                    end
                end
            end
        end else if (r_state == ccs_pkg::ST_SCAN) begin
            n_cnt = r_cnt - 6'd1;
            // head cell is examined in window order; ties go right on a rescan
            if (r_rescan ? (w_cell[0].val <= r_minv) : (w_cell[0].val < r_minv)) begin
                n_minv   = w_cell[0].val;
                n_minpos = w_cell[0].pos;
                n_minok  = 1'b1;
            end
        end
        w_new.val = w_ys;
        w_new.pos = n_spos;
    end

    // Row of window cells: fill by slot, then shift the live cells left and append
    // at the tail, or rotate the live cells for a scan; cells past the window hold
    for (genvar j = 0; j < ccs_pkg::MaxWindow; j++) begin : g_cell
        ccs_pkg::t_entry w_in;
        logic            w_tail, w_live, w_en;
        assign w_tail = (w_w - 6'd1) == 6'(j);
        assign w_live = 6'(j) < w_w;
        assign w_en   = w_cell_en && ((w_rotate || !w_slot) ? w_live : (w_fill0 == 6'(j)));
        if (j == ccs_pkg::MaxWindow - 1) begin : g_end
            assign w_in = w_rotate ? w_cell[0] : w_new;
        end else begin : g_mid
            assign w_in = w_rotate ? (w_tail ? w_cell[0] : w_cell[j + 1])
                                   : ((w_slot || w_tail) ? w_new : w_cell[j + 1]);
        end
        ccs_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_entry (w_in),
            .o_entry (w_cell[j])
        );
    end

    ccs_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (r_yk),
        .o_done  (w_hash_done),
        .o_hash  (w_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= 6'd20;
            r_s      <= 6'd16;
            r_state  <= ccs_pkg::ST_IDLE;
            r_fk     <= '0;
            r_rk     <= '0;
            r_fs     <= '0;
            r_rs     <= '0;
            r_run    <= '0;
            r_fill   <= '0;
            r_minv   <= '1;
            r_minpos <= '0;
            r_minok  <= 1'b0;
            r_idx    <= '0;
            r_off    <= '0;
            r_cnt    <= '0;
            r_rescan <= 1'b0;
            r_outv   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ccs_pkg::CfgKmer: r_k <= i_cfg_data;
                    ccs_pkg::CfgSmer: r_s <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_fk     <= n_fk;
            r_rk     <= n_rk;
            r_fs     <= n_fs;
            r_rs     <= n_rs;
            r_run    <= n_run;
            r_fill   <= n_fill;
            r_minv   <= n_minv;
            r_minpos <= n_minpos;
            r_minok  <= n_minok;
            r_idx    <= n_idx;
            r_off    <= n_off;
            r_cnt    <= n_cnt;
            r_rescan <= n_rescan;
            r_outv   <= (n_state == ccs_pkg::ST_OUT);
        end
        r_spos <= n_spos;
        r_yk   <= n_yk;
        r_kpos <= n_kpos;
    end

    assign o_out.valid         = r_outv;
    assign o_out.kmer_hash     = w_hash;
    assign o_out.kmer_position = r_kpos;

`ifndef NO_ASSERTIONS
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outv |-> r_state == ccs_pkg::ST_OUT)
        else $error("result word shown outside the output state");
    a_scan_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ccs_pkg::ST_SCAN |-> r_cnt != 6'd0)
        else $error("scan running with empty count");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 6'd32)
        else $error("window fill beyond the cell row");
    a_hash_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> $past(r_state) == ccs_pkg::ST_HASH)
        else $error("hash finished outside the hash state");
`endif
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the canonical closed-syncmer sampler.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned StallLimit = 20000;

    typedef struct packed {
        logic [63:0] kmer_hash;
        logic [31:0] kmer_position;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [5:0]  i_cfg_data;

    ccs_in_if  in_ch ();
    ccs_out_if out_ch ();

    canonical_closed_syncmer_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Predictor state, mirrored from the block's architectural state.
    logic [5:0]  k_len, s_len;
    logic [63:0] fwd_k, rev_k, fwd_s, rev_s;
    logic [31:0] run_len;
    logic [63:0] win_val [ccs_pkg::MaxWindow];
    logic [31:0] win_pos [ccs_pkg::MaxWindow];
    int unsigned win_fill;
    logic [63:0] min_val;
    logic        min_ok;
    logic [31:0] min_pos;
    logic [31:0] base_idx;
    logic [31:0] seq_base;

    t_sample     pending_samples[$];
    int          fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned sink_gap = 0;
    logic        draining;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] xxh_of_word(input logic [63:0] v);
        logic [63:0] h;
        logic [63:0] m;
        m = v * ccs_pkg::Xp2;
        h = ccs_pkg::Xp5 + 64'd8;
        h ^= rot64(m, 31) * ccs_pkg::Xp1;
        h = rot64(h, 27) * ccs_pkg::Xp1 + ccs_pkg::Xp4;
        h ^= h >> 33;
        h *= ccs_pkg::Xp2;
        h ^= h >> 29;
        h *= ccs_pkg::Xp3;
        h ^= h >> 32;
        return h;
    endfunction

    function automatic int code_of(input logic [7:0] ch);
        case (ch)
            "A", "a": return 0;
            "C", "c": return 1;
            "G", "g": return 2;
            "T", "t": return 3;
            default:  return 4;
        endcase
    endfunction

    function automatic logic [63:0] mask_for(input logic [5:0] n);
        return (n >= 6'd32) ? AllOnes : ((64'd1 << (2 * n)) - 64'd1);
    endfunction

    task automatic clear_run();
        fwd_k = '0; rev_k = '0; fwd_s = '0; rev_s = '0;
        run_len = '0;
        win_fill = 0;
        min_val = AllOnes;
        min_ok = 1'b0;
        min_pos = '0;
    endtask

    // Advance the predictor by one base and queue a sample on a closed syncmer.
    task automatic predict_sample(input logic [7:0] ch, input logic first,
                                  input logic [31:0] offs);
        logic [31:0] idx, spos;
        logic [63:0] sval, dropped, kval;
        logic [63:0] c;
        int unsigned w;
        t_sample smp;
        if (first) begin
            clear_run();
            base_idx = '0;
            seq_base = offs;
        end
        idx = base_idx;
        base_idx = idx + 1;
        if (k_len == 0 || s_len == 0 || k_len > 32 || s_len > k_len) begin
            clear_run();
            return;
        end
        if (code_of(ch) > 3) begin
            clear_run();
            return;
        end
        c = 64'(code_of(ch));
        fwd_k = ((fwd_k << 2) | c) & mask_for(k_len);
        rev_k = (rev_k >> 2) | ((64'd3 - c) << ((k_len - 1) * 2));
        fwd_s = ((fwd_s << 2) | c) & mask_for(s_len);
        rev_s = (rev_s >> 2) | ((64'd3 - c) << ((s_len - 1) * 2));
        if (run_len != 32'hFFFF_FFFF) run_len++;
        if (run_len < s_len) return;
        sval = (fwd_s < rev_s) ? fwd_s : rev_s;
        w = k_len - s_len + 1;
        spos = idx - 32'(s_len) + 1;
        if (win_fill + 1 < w) begin
            win_val[win_fill] = sval;
            win_pos[win_fill] = spos;
            win_fill++;
            return;
        end else if (win_fill + 1 == w) begin
            win_val[win_fill] = sval;
            win_pos[win_fill] = spos;
            win_fill = w;
            // Leftmost strict minimum on first fill.
            for (int j = 0; j < w; j++)
                if (win_val[j] < min_val) begin
                    min_val = win_val[j];
                    min_pos = win_pos[j];
                    min_ok = 1'b1;
                end
        end else begin
            dropped = win_val[0];
            for (int j = 0; j < w - 1; j++) begin
                win_val[j] = win_val[j + 1];
                win_pos[j] = win_pos[j + 1];
            end
            win_val[w - 1] = sval;
            win_pos[w - 1] = spos;
            if (dropped == min_val) begin
                // Minimum left the window: rescan, rightmost wins.
                min_val = AllOnes;
                min_pos = spos;
                min_ok = 1'b1;
                for (int j = w; j > 0; j--)
                    if (win_val[j - 1] < min_val) begin
                        min_val = win_val[j - 1];
                        min_pos = win_pos[j - 1];
                    end
            end else if (sval < min_val) begin
                min_val = sval;
                min_pos = spos;
                min_ok = 1'b1;
            end
        end
        if (!(min_ok && (min_pos == win_pos[w - 1] || min_pos == win_pos[0]))) return;
        kval = (fwd_k < rev_k) ? fwd_k : rev_k;
        smp.kmer_hash = xxh_of_word(kval);
        smp.kmer_position = seq_base + idx - 32'(k_len) + 1;
        pending_samples = {pending_samples, smp};
    endtask

    // Send one word after a random gap; predict it once accepted.
    task automatic send_base(input logic [7:0] ch, input logic first,
                             input logic [31:0] offs);
        int unsigned gap;
        gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.nucleotide <= ch;
        in_ch.first_of_sequence <= first;
        in_ch.sequence_offset <= offs;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_sample(ch, first, offs);
    endtask

    // Hold until every expected sample has arrived, then let the block settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ccs_pkg::CfgKmer) k_len = val;
        else s_len = val;
    endtask

    function automatic logic [7:0] rand_acgt();
        logic [7:0] tbl [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        return tbl[$urandom_range(0, 7)];
    endfunction

    // Random sequences: mostly clean bases, with occasional breaks and noise.
    task automatic run_sequences(input int n_items, input int break_pct);
        logic [7:0] ch;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < break_pct) ch = 8'($urandom);
            else ch = rand_acgt();
            send_base(ch, (n == 0) || ($urandom_range(0, 199) == 0), $urandom);
        end
    endtask

    task automatic test_directed();
        string seq_txt = "ACGTacgtTTGCAaa";
        // Offset near wrap, every base in both cases, a break, a new sequence.
        send_base("A", 1'b1, 32'hFFFF_FFF0);
        foreach (seq_txt[i]) send_base(seq_txt[i], 1'b0, '0);
        send_base("N", 1'b0, '0);
        send_base(8'hFF, 1'b0, '0);
        send_base(8'h00, 1'b0, '0);
        for (int i = 0; i < 6; i++) send_base(rand_acgt(), 1'b0, 32'hFFFF_FFFF);
        send_base("G", 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_lengths();
        // k == s (window of one), k = 1, full k = 32 with s = 1 (widest window), k = s = 32, k = 11 with s = 3.
        write_reg(ccs_pkg::CfgKmer, 6'd5);  write_reg(ccs_pkg::CfgSmer, 6'd5);
        run_sequences(120, 2);
        write_reg(ccs_pkg::CfgKmer, 6'd1);  write_reg(ccs_pkg::CfgSmer, 6'd1);
        run_sequences(60, 3);
        write_reg(ccs_pkg::CfgKmer, 6'd32); write_reg(ccs_pkg::CfgSmer, 6'd1);
        run_sequences(200, 1);
        write_reg(ccs_pkg::CfgSmer, 6'd32);
        run_sequences(150, 1);
        write_reg(ccs_pkg::CfgKmer, 6'd11); write_reg(ccs_pkg::CfgSmer, 6'd3);
        run_sequences(300, 5);
    endtask

    task automatic test_invalid_lengths();
        // s above k, zero lengths and k above 32 sample nothing.
        write_reg(ccs_pkg::CfgKmer, 6'd4);  write_reg(ccs_pkg::CfgSmer, 6'd9);
        run_sequences(40, 0);
        write_reg(ccs_pkg::CfgKmer, 6'd0);
        run_sequences(20, 0);
        write_reg(ccs_pkg::CfgKmer, 6'd63); write_reg(ccs_pkg::CfgSmer, 6'd0);
        run_sequences(20, 0);
        write_reg(ccs_pkg::CfgKmer, 6'd40); write_reg(ccs_pkg::CfgSmer, 6'd3);
        run_sequences(20, 0);
    endtask

    task automatic test_random();
        for (int r = 0; r < 8; r++) begin
            write_reg(ccs_pkg::CfgKmer, 6'($urandom_range(1, 32)));
            write_reg(ccs_pkg::CfgSmer, 6'($urandom_range(1, k_len)));
            run_sequences(80, $urandom_range(0, 6));
        end
    endtask

    // Sink side: draw a wait before each word, check each accepted sample.
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_samples.size() == 0) begin
                    $display("%0t unexpected sample: got hash %h pos %h", $time,
                             out_ch.kmer_hash, out_ch.kmer_position);
                    fail_count++;
                end else begin
                    exp_s = pending_samples.pop_front();
                    if (out_ch.kmer_hash !== exp_s.kmer_hash) begin
                        $display("%0t hash mismatch: expected %h actual %h", $time,
                                 exp_s.kmer_hash, out_ch.kmer_hash);
                        fail_count++;
                    end
                    if (out_ch.kmer_position !== exp_s.kmer_position) begin
                        $display("%0t position mismatch: expected %h actual %h", $time,
                                 exp_s.kmer_position, out_ch.kmer_position);
                        fail_count++;
                    end
                end
                sink_gap = $urandom_range(0, 17);
            end
            if (sink_gap != 0 && !draining) begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        draining = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = ccs_pkg::CfgKmer;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.nucleotide = '0;
        in_ch.first_of_sequence = 1'b0;
        in_ch.sequence_offset = '0;
        k_len = 6'd20;
        s_len = 6'd16;
        base_idx = '0;
        seq_base = '0;
        clear_run();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        run_sequences(150, 2);
        test_lengths();
        test_invalid_lengths();
        test_random();
        draining = 1'b1;
        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== canonical_closed_syncmer_sampler.f =====
src/ccs_pkg.sv
src/ccs_if.sv
src/ccs_cell.sv
src/ccs_hash.sv
src/canonical_closed_syncmer_sampler.sv
tb/tb_top.sv
